// ----- sv/mf3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_pkg: shared types, constants and sort helpers
// Column and queue entry types, command and register codes, and the small
// min/max networks used by the 3x3 median datapath.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int PIX_W       = 8;
  localparam int FW_W        = 11;  // frame_width register
  localparam int FH_W        = 12;  // frame_height register
  localparam int CFG_W       = 12;  // widest register
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // one sorted column of three pixels
  typedef struct packed {
    pix_t lo;
    pix_t mid;
    pix_t hi;
  } col_t;

  // one column handed from the front to the back
  typedef struct packed {
    col_t col;
    logic first_col;  // left edge: column fills left and center slots
    logic last_col;   // right edge: second result for the rightmost center
    logic frame_end;  // final column of the drain
  } qent_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort3(pix_t a, pix_t b, pix_t c);
    col_t s;
    s.lo  = min2(min2(a, b), c);
    s.mid = med3(a, b, c);
    s.hi  = max2(max2(a, b), c);
    return s;
  endfunction

  // median of nine from three sorted columns
  function automatic pix_t win_med(col_t l, col_t m, col_t r);
    return med3(max2(max2(l.lo, m.lo), r.lo),
                med3(l.mid, m.mid, r.mid),
                min2(min2(l.hi, m.hi), r.hi));
  endfunction

endpackage

// ----- sv/mf3_line_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_line_front: position tracking, line stores and column sort
// Accepts items, tracks column/row/drain state, reads and updates the two
// line stores and pushes one sorted column per producing item.
// ----------------------------------------------------------------------------
module mf3_line_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [mf3_pkg::FW_W-1:0]          frame_width,
  input  logic [mf3_pkg::FH_W-1:0]          frame_height,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [mf3_pkg::PIX_W-1:0]         pixel_in,
  input  logic [mf3_pkg::QCNT_W-1:0]        q_level,
  output logic                              push,
  output mf3_pkg::qent_t                    push_data
);
  import mf3_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

  // line stores
  pix_t row_above     [MAX_WIDTH];
  pix_t row_two_above [MAX_WIDTH];
  pix_t above_q, two_q;

  logic [CW-1:0]   col_idx;
  logic [FH_W-1:0] row_idx;
  logic            draining;

  logic [WW-1:0]   eff_w, c_plus;
  logic [FH_W-1:0] eff_h;
  logic [FH_W:0]   r_plus;
  logic [CW-1:0]   c_cur;
  logic [FH_W-1:0] r_cur;
  logic            is_drain, accept, take_item, last_col, row_end;

  // column in flight, registered together with the line store read
  logic          s1_valid, s1_pixel, s1_enq, s1_first, s1_last, s1_end, s1_t_is_m;
  logic [CW-1:0] s1_c;
  pix_t          s1_px;
  logic          s1_fwd;
  pix_t          fwd_above, fwd_two;
  pix_t          s1_above, s1_two, s1_top, s1_bot;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if (WW'(frame_width) > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
  end

  assign eff_h     = (frame_height == '0) ? FH_W'(1) : frame_height;
  assign in_ready  = ({1'b0, q_level} + (QCNT_W + 1)'(s1_valid)) < (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept    = in_valid && in_ready;
  assign is_drain  = (command == CMD_DRAIN);
  // drain items outside the drain phase are dropped
  assign take_item = accept && (!is_drain || draining);

  // a pixel item during the drain restarts at the frame origin
  assign c_cur    = (!is_drain && draining) ? '0 : col_idx;
  assign r_cur    = (!is_drain && draining) ? '0 : row_idx;
  assign c_plus   = WW'(c_cur) + WW'(1);
  assign last_col = (c_plus >= eff_w);
  assign r_plus   = {1'b0, r_cur} + (FH_W + 1)'(1);
  assign row_end  = (r_plus >= {1'b0, eff_h});

  always_ff @(posedge clk) begin
    if (rst) begin
      col_idx  <= '0;
      row_idx  <= '0;
      draining <= 1'b0;
    end else if (take_item) begin
      if (is_drain) begin
        if (last_col) begin
          col_idx  <= '0;
          row_idx  <= '0;
          draining <= 1'b0;
        end else begin
          col_idx <= CW'(c_plus);
        end
      end else begin
        col_idx  <= last_col ? '0 : CW'(c_plus);
        row_idx  <= (last_col && !row_end) ? r_plus[FH_W-1:0] : r_cur;
        draining <= last_col && row_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else begin
      s1_valid <= take_item;
      // the previous column's store write lands on the edge this read is taken
      s1_fwd   <= take_item && s1_valid && s1_pixel && (s1_c == c_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (take_item) begin
      s1_c      <= c_cur;
      s1_px     <= pixel_in;
      s1_pixel  <= !is_drain;
      s1_enq    <= is_drain || (r_cur != '0);
      s1_first  <= (c_cur == '0);
      s1_last   <= last_col;
      s1_end    <= is_drain && last_col;
      s1_t_is_m <= is_drain ? (r_cur == '0) : (r_cur == FH_W'(1));
      fwd_above <= s1_px;
      fwd_two   <= s1_above;
    end
  end

  always_ff @(posedge clk) begin
    if (take_item) begin
      above_q <= row_above[c_cur];
      two_q   <= row_two_above[c_cur];
    end
    if (s1_valid && s1_pixel) begin
      row_above[s1_c]     <= s1_px;
      row_two_above[s1_c] <= s1_above;
    end
  end

  assign s1_above = s1_fwd ? fwd_above : above_q;
  assign s1_two   = s1_fwd ? fwd_two : two_q;
  assign s1_top   = s1_t_is_m ? s1_above : s1_two;
  assign s1_bot   = s1_pixel ? s1_px : s1_above;  // bottom edge repeats middle row

  assign push                = s1_valid && s1_enq;
  assign push_data.col       = sort3(s1_top, s1_above, s1_bot);
  assign push_data.first_col = s1_first;
  assign push_data.last_col  = s1_last;
  assign push_data.frame_end = s1_end;

  a_fwd_follows_pixel: assert property (@(posedge clk) disable iff (rst)
    s1_fwd |-> s1_valid && $past(s1_valid && s1_pixel))
    else $error("forwarding without a preceding store write");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    push && push_data.frame_end |-> push_data.last_col)
    else $error("frame end on a column that is not last");

endmodule

// ----- sv/mf3_col_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_col_queue: short column queue between front and back
// Small first-in first-out buffer of sorted columns with a fill level.
// ----------------------------------------------------------------------------
module mf3_col_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  mf3_pkg::qent_t              push_data,
  input  logic                        pop,
  output logic                        head_valid,
  output mf3_pkg::qent_t              head,
  output logic [mf3_pkg::QCNT_W-1:0]  level
);
  import mf3_pkg::*;

  qent_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign level      = count;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < QCNT_W'(QUEUE_DEPTH)))
    else $error("column queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("column queue underflow");

endmodule

// ----- sv/mf3_window_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_window_back: sliding window and result output
// Keeps the left and center sorted columns, forms up to two medians per
// column and delivers them through an output register and a spare slot.
// ----------------------------------------------------------------------------
module mf3_window_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  mf3_pkg::qent_t              head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mf3_pkg::PIX_W-1:0]   median_out,
  output logic                        frame_last
);
  import mf3_pkg::*;

  col_t win_l, win_m, nxt_l, nxt_m;
  pix_t res_a, res_b;
  logic slot_free;

  // second result of a last column waits here
  logic pend_valid;
  pix_t pend_med;
  logic pend_last;

  assign slot_free = !out_valid || out_ready;
  // a left-edge column that gives no result may enter while the spare leaves
  assign pop       = head_valid && slot_free &&
                     (!pend_valid || (head.first_col && !head.last_col));

  assign res_a = win_med(win_l, win_m, head.col);
  assign nxt_l = head.first_col ? head.col : win_m;
  assign nxt_m = head.col;
  assign res_b = win_med(nxt_l, nxt_m, nxt_m);  // right edge replicated

  always_ff @(posedge clk) begin
    if (rst) begin
      win_l <= '0;
      win_m <= '0;
    end else if (pop) begin
      win_l <= nxt_l;
      win_m <= nxt_m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && slot_free) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (pop && (!head.first_col || head.last_col)) begin
        out_valid  <= 1'b1;
        pend_valid <= !head.first_col && head.last_col;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid && slot_free) begin
      median_out <= pend_med;
      frame_last <= pend_last;
    end else if (pop) begin
      if (!head.first_col) begin
        median_out <= res_a;
        frame_last <= 1'b0;
        pend_med   <= res_b;
        pend_last  <= head.frame_end;
      end else begin
        median_out <= res_b;
        frame_last <= head.frame_end;
      end
    end
  end

  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("spare result held without an output result");

  a_pend_loaded: assert property (@(posedge clk) disable iff (rst)
    pend_valid && out_ready |=> out_valid && !pend_valid)
    else $error("spare result not moved to output");

endmodule

// ----- sv/median_filter_3x3_stream.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_stream: streaming 3x3 median filter, replicated edges
// Raster-order 8-bit pixels in, exact 3x3 medians out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): command selects a pixel item or a
//   drain item; pixel_in carries the pixel. Pixel items past column 0 yield the median
//   for the center one row up and one column left; the last column of a row
//   yields a second result. The first row gives no results. After the final
//   pixel of the frame, frame_width drain items flush out the last row;
//   drain items outside that phase are accepted and dropped.
//   Output channel (out_valid/out_ready): median_out, with frame_last set on
//   the frame's very last result.
//   Config: cfg_write with cfg_index/cfg_data sets frame_width (index 0) or
//   frame_height (index 1); write only while the block is idle.
//   Path: item and line store reads registered; column queued; result registered.
//   Throughput: one item per clock while the queue has room; line stores read
//   at accept, written in the cycle after with a same-column bypass. A last
//   column's second result leaves while the next row's first column, which
//   gives none, enters the window.
//   Reset: counters, drain state and window clear; frame size returns to
//   640x480. Line stores are not cleared.
//   Stall: when out_ready is low, the output register and spare slot hold;
//   the queue fills and in_ready drops once it has no room.
// ----------------------------------------------------------------------------
module median_filter_3x3_stream #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]         cfg_data,
  // input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [mf3_pkg::PIX_W-1:0]         pixel_in,
  // result items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mf3_pkg::PIX_W-1:0]         median_out,
  output logic                              frame_last
);
  import mf3_pkg::*;

  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;

  // front to queue
  logic              push;
  qent_t             push_data;
  // queue to back
  logic              pop, head_valid;
  qent_t             head;
  logic [QCNT_W-1:0] q_level;

  // frame size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(640);
      frame_height <= FH_W'(480);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // front: position tracking, line stores, column sort
  mf3_line_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .pixel_in     (pixel_in),
    .q_level      (q_level),
    .push         (push),
    .push_data    (push_data)
  );

  // decoupling queue of sorted columns
  mf3_col_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .level      (q_level)
  );

  // back: window slide and median output
  mf3_window_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .median_out (median_out),
    .frame_last (frame_last)
  );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for median_filter_3x3_stream
// Drives raster-order pixel and drain items through a valid/ready channel,
// predicts every 3x3 median (replicated edges) in a local window model and
// compares each result item, median and frame_last flag, in order. Covers
// directed edge sizes, size changes, abandoned drains, long output stalls
// and random frames.
// ----------------------------------------------------------------------------
module tb_top;
  import mf3_pkg::*;

  localparam int MAX_W    = 1024;
  localparam int IDLE_PCT = 34;
  localparam int SETTLE   = 8;    // clocks for the pipeline to go quiet
  localparam int MAX_MSGS = 200;

  typedef struct {
    pix_t median;
    logic is_last;
  } median_rec_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 command;
  pix_t                 pixel_in;
  logic                 out_valid;
  logic                 out_ready;
  pix_t                 median_out;
  logic                 frame_last;

  median_filter_3x3_stream #(.MAX_WIDTH(MAX_W)) dut (.*);

  // medians still owed by the block, oldest first
  median_rec_t exp_medians[$];

  // window model: line stores, three sorted columns, raster position
  pix_t            line_prev  [MAX_W];
  pix_t            line_prev2 [MAX_W];
  col_t            win_col    [3];    // 0 = left, 1 = center, 2 = newest
  int unsigned     col_pos;
  int unsigned     row_pos;
  bit              in_drain;
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;

  // stimulus knobs and bookkeeping
  int tx_gap_pct   = IDLE_PCT;
  int rx_stall_pct = IDLE_PCT;
  int rx_hold_req  = 0;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned frames_seen;
  int unsigned in_stall_cycles;
  int unsigned fail_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Window model
  // ---------------------------------------------------------------------
  function automatic pix_t lesser(pix_t a, pix_t b);
    return (b < a) ? b : a;
  endfunction

  function automatic pix_t greater(pix_t a, pix_t b);
    return (b > a) ? b : a;
  endfunction

  // middle value = sum minus the two extremes
  function automatic col_t order3(pix_t a, pix_t b, pix_t c);
    col_t s;
    int   total;
    total = int'(a) + int'(b) + int'(c);
    s.lo  = lesser(lesser(a, b), c);
    s.hi  = greater(greater(a, b), c);
    s.mid = pix_t'(total - int'(s.lo) - int'(s.hi));
    return s;
  endfunction

  function automatic pix_t center_median(col_t l, col_t m, col_t r);
    col_t mids;
    mids = order3(greater(greater(l.lo, m.lo), r.lo),
                  order3(l.mid, m.mid, r.mid).mid,
                  lesser(lesser(l.hi, m.hi), r.hi));
    return mids.mid;
  endfunction

  function automatic int unsigned span_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned span_h();
    return (height_reg == 0) ? 1 : 32'(height_reg);
  endfunction

  task automatic owe_median(input pix_t med, input logic fin);
    median_rec_t rec;
    rec.median  = med;
    rec.is_last = fin;
    exp_medians.push_back(rec);
  endtask

  // slide one column into the window; left edge replicates, right edge adds
  // a second median with the center column repeated
  task automatic shift_column(input int unsigned c, input pix_t t, input pix_t m,
                              input pix_t b, input bit last_c, input bit fin);
    win_col[2] = order3(t, m, b);
    if (c == 0) begin
      win_col[0] = win_col[2];
      win_col[1] = win_col[2];
    end else begin
      owe_median(center_median(win_col[0], win_col[1], win_col[2]), 1'b0);
      win_col[0] = win_col[1];
      win_col[1] = win_col[2];
    end
    if (last_c) owe_median(center_median(win_col[0], win_col[1], win_col[1]), fin);
  endtask

  task automatic advance_window(input logic cmd, input pix_t px);
    int unsigned w, h, c, r;
    bit          last_c;
    pix_t        t, m;
    w = span_w();
    h = span_h();
    if (cmd == CMD_DRAIN) begin
      if (!in_drain) return;        // stray drain: dropped
      c      = col_pos % MAX_W;
      r      = row_pos;
      last_c = (c + 1 >= w);
      m      = line_prev[c];
      t      = (r == 0) ? m : line_prev2[c];
      shift_column(c, t, m, m, last_c, last_c);
      if (last_c) begin
        in_drain = 1'b0;
        row_pos  = 0;
        col_pos  = 0;
      end else begin
        col_pos = c + 1;
      end
      return;
    end
    // pixel during drain starts a new frame
    if (in_drain) begin
      in_drain = 1'b0;
      row_pos  = 0;
      col_pos  = 0;
    end
    c      = col_pos % MAX_W;
    r      = row_pos;
    last_c = (c + 1 >= w);
    if (r >= 1) begin
      m = line_prev[c];
      t = (r == 1) ? m : line_prev2[c];
      shift_column(c, t, m, px, last_c, 1'b0);
    end
    line_prev2[c] = line_prev[c];
    line_prev[c]  = px;
    if (last_c) begin
      col_pos = 0;
      if (r + 1 >= h) in_drain = 1'b1;
      else row_pos = (r + 1) & 12'hFFF;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // ---------------------------------------------------------------------
  // Drivers (all called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------

  // valid stays up between back-to-back items; it drops only on a gap or when idle
  task automatic send_item(input logic cmd, input pix_t px);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    pixel_in <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_window(cmd, px);
    items_sent++;
    @(negedge clk);
  endtask

  // sender pauses until every owed median has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (exp_medians.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // both registers in one burst so cfg_write never bounces within a step
  task automatic set_frame(input int unsigned w, input int unsigned h);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= CFG_W'(w);
    @(posedge clk);
    width_reg = w[FW_W-1:0];
    @(negedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= CFG_W'(h);
    @(posedge clk);
    height_reg = h[FH_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // rails, ties near mid-gray and plain noise
  function automatic pix_t pick_pixel();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    if (sel < 40) return pix_t'(8'h80 + $urandom_range(3));
    return pix_t'($urandom);
  endfunction

  // one frame at the current size, then the given number of drain items;
  // noise drops stray drains mid-frame (never first, so no drain resumes)
  task automatic send_frame(input int unsigned drains, input bit noisy);
    int unsigned npix;
    npix = span_w() * span_h();
    for (int unsigned i = 0; i < npix; i++) begin
      if (noisy && i != 0 && $urandom_range(99) < 3) send_item(CMD_DRAIN, pix_t'($urandom));
      send_item(CMD_PIXEL, pick_pixel());
    end
    repeat (drains) send_item(CMD_DRAIN, pix_t'($urandom));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // drain items with no frame pending are dropped
  task automatic test_stray_drain();
    send_item(CMD_DRAIN, 8'h00);
    send_item(CMD_DRAIN, 8'hFF);
  endtask

  // 3x3 frame with rails and ties, full drain ends on frame_last
  task automatic test_basic_frame();
    pix_t pix [9] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01, 8'hFE, 8'h80, 8'h80};
    set_frame(3, 3);
    foreach (pix[i]) send_item(CMD_PIXEL, pix[i]);
    repeat (3) send_item(CMD_DRAIN, 8'h55);
  endtask

  // width one: only the right-edge median per row
  task automatic test_single_column();
    set_frame(1, 2);
    send_item(CMD_PIXEL, 8'h10);
    send_item(CMD_PIXEL, 8'hF0);
    send_item(CMD_DRAIN, 8'hAA);
  endtask

  // height one: drain uses the single row for all three rows
  task automatic test_single_row();
    set_frame(2, 1);
    send_item(CMD_PIXEL, 8'h7F);
    send_item(CMD_PIXEL, 8'h81);
    repeat (2) send_item(CMD_DRAIN, 8'h00);
  endtask

  // zero sizes read as one; drain after the frame is done is dropped
  task automatic test_zero_size();
    set_frame(0, 0);
    send_item(CMD_PIXEL, 8'hC3);
    send_item(CMD_DRAIN, 8'h00);
    send_item(CMD_DRAIN, 8'h00);
  endtask

  // pixel item mid-drain abandons the drain and opens a new frame
  task automatic test_drain_abandon();
    set_frame(2, 1);
    send_item(CMD_PIXEL, 8'h20);
    send_item(CMD_PIXEL, 8'hE0);
    send_item(CMD_DRAIN, 8'h00);
    send_item(CMD_PIXEL, 8'h01);
    send_item(CMD_PIXEL, 8'hFE);
    repeat (2) send_item(CMD_DRAIN, 8'h00);
  endtask

  // shrink width with the column past the new edge, then height with the
  // row past the new last row
  task automatic test_resize_midframe();
    set_frame(4, 3);
    repeat (6) send_item(CMD_PIXEL, pick_pixel());
    set_frame(2, 3);
    send_item(CMD_PIXEL, pick_pixel());
    set_frame(2, 1);
    repeat (2) send_item(CMD_PIXEL, pick_pixel());
    repeat (2) send_item(CMD_DRAIN, 8'h00);
  endtask

  // wide frame streamed with no idling on either side
  task automatic test_no_idle_burst();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    set_frame(64, 4);
    send_frame(span_w(), 1'b0);
    wait_idle();
    tx_gap_pct   = IDLE_PCT;
    rx_stall_pct = IDLE_PCT;
  endtask

  // output held off long enough for the queue to fill and in_ready to drop
  task automatic test_backpressure();
    set_frame(8, 4);
    tx_gap_pct  = 0;
    rx_hold_req = 150;
    send_frame(span_w(), 1'b0);
    wait_idle();
    tx_gap_pct = IDLE_PCT;
  endtask

  // random sizes, a few frames each; some drains cut short or overrun
  task automatic test_random_frames();
    int unsigned first_item, w, h, sel, reps;
    first_item = items_sent;
    while (items_sent - first_item < 900) begin
      sel = $urandom_range(99);
      if (sel < 5) w = 0;
      else if (sel < 70) w = $urandom_range(1, 8);
      else w = $urandom_range(9, 40);
      h = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 6);
      set_frame(w, h);
      reps = $urandom_range(1, 3);
      repeat (reps) begin
        sel = $urandom_range(9);
        if (sel == 0) send_frame($urandom_range(span_w() - 1), 1'b1);
        else if (sel == 1) send_frame(span_w() + $urandom_range(1, 3), 1'b1);
        else send_frame(span_w(), 1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // receiver: random stalls, or a counted hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // every accepted result against the oldest owed median
  always @(posedge clk) begin : check_results
    median_rec_t want;
    if (!rst) begin
      if (in_valid && !in_ready) in_stall_cycles++;
      if (out_valid && out_ready) begin
        results_seen++;
        if (exp_medians.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_MSGS)
            $display("%0t: unexpected result: expected none, got median %0d last %0b",
                     $time, median_out, frame_last);
        end else begin
          want = exp_medians.pop_front();
          if (want.is_last) frames_seen++;
          if (median_out !== want.median) begin
            fail_count++;
            if (fail_count <= MAX_MSGS)
              $display("%0t: median_out mismatch: expected %0d, got %0d",
                       $time, want.median, median_out);
          end
          if (frame_last !== want.is_last) begin
            fail_count++;
            if (fail_count <= MAX_MSGS)
              $display("%0t: frame_last mismatch: expected %0b, got %0b",
                       $time, want.is_last, frame_last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = REG_FRAME_WIDTH;
    cfg_data   = '0;
    in_valid   = 1'b0;
    command    = CMD_PIXEL;
    pixel_in   = '0;
    width_reg  = 11'd640;
    height_reg = 12'd480;
    col_pos    = 0;
    row_pos    = 0;
    in_drain   = 1'b0;
    foreach (win_col[i]) win_col[i] = '0;
    foreach (line_prev[i]) begin
      line_prev[i]  = '0;
      line_prev2[i] = '0;
    end
    items_sent      = 0;
    results_seen    = 0;
    frames_seen     = 0;
    in_stall_cycles = 0;
    fail_count      = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_stray_drain();
    test_basic_frame();
    test_single_column();
    test_single_row();
    test_zero_size();
    test_drain_abandon();
    test_resize_midframe();
    test_no_idle_burst();
    test_backpressure();
    test_random_frames();

    wait_idle();
    repeat (20) @(negedge clk);

    $display("Covered %0d items, %0d results, %0d complete frames, widths 1 to 64",
             items_sent, results_seen, frames_seen);
    $display("Input side stalled for %0d cycles under output back-pressure", in_stall_cycles);
    if (fail_count == 0 && exp_medians.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, well past the slowest legal run
  initial begin
    #3_000_000;
    $display("Timeout with %0d results still owed", exp_medians.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
